// ===== hdl/rnd_pkg.sv =====
package rnd_pkg;

   // Field widths
   localparam int TIME_W  = 32;
   localparam int KIND_W  = 3;
   localparam int NEXT_W  = 33;
   localparam int DELTA_W = 25;
   localparam int DAYS_W  = 16;
   localparam int DOE_W   = 18;
   localparam int YOE_W   = 9;
   localparam int DOY_W   = 9;
   localparam int MP_W    = 4;

   // Recurrence kinds
   localparam logic [KIND_W-1:0] KIND_ONCE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MINUTE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HOUR    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DAY     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WEEK    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_WEEKDAY = 3'd5;
   localparam logic [KIND_W-1:0] KIND_MONTHLY = 3'd6;
   localparam logic [KIND_W-1:0] KIND_YEARLY  = 3'd7;

   // Spans in seconds
   localparam logic [DELTA_W-1:0] MINUTE_SECS = 25'd60;
   localparam logic [DELTA_W-1:0] HOUR_SECS   = 25'd3600;
   localparam logic [DELTA_W-1:0] DAY_SECS    = 25'd86400;
   localparam logic [DELTA_W-1:0] WEEK_SECS   = 25'd604800;

   // Civil date conversion, epoch 1600-03-01 (a multiple of 400 years)
   localparam logic [DOE_W-1:0] EPOCH_OFFSET = 18'd135080;
   localparam logic [DOE_W-1:0] ERA_DAYS     = 18'd146097;

   // Reciprocals for exact division by constants over the ranges used
   localparam logic [26:0] RECIP_675  = 27'd101806633;  // x < 2^26, shift 36
   localparam logic [16:0] RECIP_365Q = 17'd91930;      // x < 2^16, shift 25
   localparam logic [18:0] RECIP_365N = 19'd367720;     // x < 2^18, shift 27
   localparam logic [11:0] RECIP_153  = 12'd3427;       // x < 2^11, shift 19

   // Month codes
   localparam logic [MP_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MP_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MP_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MP_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MP_W-1:0] MONTH_NOV = 4'd11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DAYS,
      ST_ERA,
      ST_Q1460,
      ST_NUM,
      ST_YOE,
      ST_DOY,
      ST_MP,
      ST_DELTA,
      ST_SUM
   } state_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_LOAD,
      STEP_DAYS,
      STEP_ERA,
      STEP_Q1460,
      STEP_NUM,
      STEP_YOE,
      STEP_DOY,
      STEP_MP,
      STEP_DELTA,
      STEP_SUM
   } step_type;

   typedef struct packed {
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic need_date;
   } status_type;

   // First day of year (March based) for each month index
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   // Days in a calendar month (1..12)
   function automatic logic [4:0] month_len(input logic [MP_W-1:0] month,
                                            input logic leap);
      logic [4:0] n;
      if (month == MONTH_FEB) begin
         n = leap ? 5'd29 : 5'd28;
      end else if (month == MONTH_APR || month == MONTH_JUN ||
                   month == MONTH_SEP || month == MONTH_NOV) begin
         n = 5'd30;
      end else begin
         n = 5'd31;
      end
      return n;
   endfunction

endpackage

// ===== hdl/rnd_ctrl.sv =====
module rnd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  rnd_pkg::status_type status,
   output rnd_pkg::cmd_type    cmd
);

   rnd_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // State and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rnd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd.step     = rnd_pkg::STEP_NONE;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         rnd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.step = rnd_pkg::STEP_LOAD;
               state_in = rnd_pkg::ST_DAYS;
            end
         end
         rnd_pkg::ST_DAYS: begin
            cmd.step = rnd_pkg::STEP_DAYS;
            state_in = status.need_date ? rnd_pkg::ST_ERA : rnd_pkg::ST_DELTA;
         end
         rnd_pkg::ST_ERA: begin
            cmd.step = rnd_pkg::STEP_ERA;
            state_in = rnd_pkg::ST_Q1460;
         end
         rnd_pkg::ST_Q1460: begin
            cmd.step = rnd_pkg::STEP_Q1460;
            state_in = rnd_pkg::ST_NUM;
         end
         rnd_pkg::ST_NUM: begin
            cmd.step = rnd_pkg::STEP_NUM;
            state_in = rnd_pkg::ST_YOE;
         end
         rnd_pkg::ST_YOE: begin
            cmd.step = rnd_pkg::STEP_YOE;
            state_in = rnd_pkg::ST_DOY;
         end
         rnd_pkg::ST_DOY: begin
            cmd.step = rnd_pkg::STEP_DOY;
            state_in = rnd_pkg::ST_MP;
         end
         rnd_pkg::ST_MP: begin
            cmd.step = rnd_pkg::STEP_MP;
            state_in = rnd_pkg::ST_DELTA;
         end
         rnd_pkg::ST_DELTA: begin
            cmd.step = rnd_pkg::STEP_DELTA;
            state_in = rnd_pkg::ST_SUM;
         end
         rnd_pkg::ST_SUM: begin
            // wait here until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.step     = rnd_pkg::STEP_SUM;
               rsp_valid_in = 1'b1;
               state_in     = rnd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rnd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/rnd_datapath.sv =====
module rnd_datapath (
   input  logic                clock,
   input  rnd_pkg::cmd_type    cmd,
   input  logic [31:0]         req_tdata,
   input  logic [2:0]          req_tuser,
   output rnd_pkg::status_type status,
   output logic [39:0]         rsp_tdata
);

   logic [rnd_pkg::TIME_W-1:0]  time_ff;
   logic [rnd_pkg::KIND_W-1:0]  kind_ff;
   logic [rnd_pkg::DAYS_W-1:0]  days_ff;
   logic [rnd_pkg::DOE_W-1:0]   doe_ff;
   logic [6:0]                  q1460_ff;
   logic [rnd_pkg::DOE_W-1:0]   num_ff;
   logic [rnd_pkg::YOE_W-1:0]   yoe_ff;
   logic [rnd_pkg::DOY_W-1:0]   doy_ff;
   logic [rnd_pkg::MP_W-1:0]    mp_ff;
   logic [rnd_pkg::DELTA_W-1:0] delta_ff;
   logic [rnd_pkg::NEXT_W-1:0]  next_ff;

   logic [51:0]                 days_prod;
   logic [rnd_pkg::DOE_W-1:0]   z_day;
   logic [rnd_pkg::DOE_W-1:0]   doe_in;
   logic [32:0]                 q_prod;
   logic [rnd_pkg::DOE_W-1:0]   num_in;
   logic [36:0]                 yoe_prod;
   logic [rnd_pkg::DOE_W-1:0]   doy_in;
   logic [22:0]                 mp_prod;
   logic [rnd_pkg::DELTA_W-1:0] delta_in;

   // Day count: (t >> 7) / 675
   assign days_prod = 52'(time_ff[31:7]) * 52'(rnd_pkg::RECIP_675);

   // Day of era, era 0 or 1 over the input range
   always_comb begin
      z_day  = 18'(days_ff) + rnd_pkg::EPOCH_OFFSET;
      doe_in = (z_day >= rnd_pkg::ERA_DAYS) ? z_day - rnd_pkg::ERA_DAYS : z_day;
   end

   // doe / 1460 as (doe >> 2) / 365
   assign q_prod = 33'(doe_ff[17:2]) * 33'(rnd_pkg::RECIP_365Q);

   // doe - doe/1460 + doe/36524 - doe/146096
   always_comb begin
      logic [2:0] c_cent;
      c_cent = 3'(doe_ff >= 18'd36524) + 3'(doe_ff >= 18'd73048) +
               3'(doe_ff >= 18'd109572) + 3'(doe_ff >= 18'd146096);
      num_in = doe_ff - 18'(q1460_ff) + 18'(c_cent) - 18'(doe_ff == 18'd146096);
   end

   // Year of era
   assign yoe_prod = 37'(num_ff) * 37'(rnd_pkg::RECIP_365N);

   // Day of (March based) year
   always_comb begin
      logic [1:0]               c_hund;
      logic [rnd_pkg::DOE_W-1:0] ybase;
      c_hund = 2'(yoe_ff >= 9'd100) + 2'(yoe_ff >= 9'd200) + 2'(yoe_ff >= 9'd300);
      ybase  = 18'(yoe_ff) * 18'd365 + 18'(yoe_ff[8:2]) - 18'(c_hund);
      doy_in = doe_ff - ybase;
   end

   // Month index (5 * doy + 2) / 153
   assign mp_prod = 23'(11'(doy_ff) * 11'd5 + 11'd2) * 23'(rnd_pkg::RECIP_153);

   // Span to add for the kind
   always_comb begin
      logic [rnd_pkg::MP_W-1:0]  month;
      logic                      jan_feb;
      logic [rnd_pkg::YOE_W-1:0] yoe_adj;
      logic                      leap;
      logic [4:0]                mlen;
      logic [4:0]                dom0;
      logic [4:0]                rest;
      logic [2:0]                weeks;
      jan_feb = (mp_ff >= 4'd10);
      month   = jan_feb ? mp_ff - 4'd9 : mp_ff + 4'd3;
      yoe_adj = yoe_ff + 9'(jan_feb);
      // base year is a multiple of 400, so only the year of era matters
      leap    = (yoe_adj[1:0] == 2'd0) && (yoe_adj != 9'd100) &&
                (yoe_adj != 9'd200) && (yoe_adj != 9'd300);
      mlen    = rnd_pkg::month_len(month, leap);
      dom0    = 5'(doy_ff - rnd_pkg::month_start(mp_ff));
      rest    = mlen - 5'd1 - dom0;
      // whole weeks until the month turns over
      weeks   = 3'd1 + 3'(rest >= 5'd7) + 3'(rest >= 5'd14) +
                3'(rest >= 5'd21) + 3'(rest >= 5'd28);
      case (kind_ff)
         rnd_pkg::KIND_ONCE:    delta_in = '0;
         rnd_pkg::KIND_MINUTE:  delta_in = rnd_pkg::MINUTE_SECS;
         rnd_pkg::KIND_HOUR:    delta_in = rnd_pkg::HOUR_SECS;
         rnd_pkg::KIND_DAY:     delta_in = rnd_pkg::DAY_SECS;
         rnd_pkg::KIND_WEEK:    delta_in = rnd_pkg::WEEK_SECS;
         rnd_pkg::KIND_WEEKDAY: delta_in = 25'(weeks) * rnd_pkg::WEEK_SECS;
         rnd_pkg::KIND_MONTHLY: delta_in = 25'(mlen) * rnd_pkg::DAY_SECS;
         default:               delta_in = (leap ? 25'd366 : 25'd365) * rnd_pkg::DAY_SECS;
      endcase
   end

   // Step registers
   always_ff @(posedge clock) begin
      case (cmd.step)
         rnd_pkg::STEP_LOAD: begin
            time_ff <= req_tdata;
            kind_ff <= req_tuser;
         end
         rnd_pkg::STEP_DAYS:  days_ff  <= days_prod[51:36];
         rnd_pkg::STEP_ERA:   doe_ff   <= doe_in;
         rnd_pkg::STEP_Q1460: q1460_ff <= q_prod[31:25];
         rnd_pkg::STEP_NUM:   num_ff   <= num_in;
         rnd_pkg::STEP_YOE:   yoe_ff   <= yoe_prod[35:27];
         rnd_pkg::STEP_DOY:   doy_ff   <= doy_in[8:0];
         rnd_pkg::STEP_MP:    mp_ff    <= mp_prod[22:19];
         rnd_pkg::STEP_DELTA: delta_ff <= delta_in;
         rnd_pkg::STEP_SUM:   next_ff  <= 33'(time_ff) + 33'(delta_ff);
         default: begin
         end
      endcase
   end

   assign status.need_date = (kind_ff == rnd_pkg::KIND_WEEKDAY) ||
                             (kind_ff == rnd_pkg::KIND_MONTHLY) ||
                             (kind_ff == rnd_pkg::KIND_YEARLY);

   assign rsp_tdata = {7'd0, next_ff};

endmodule

// ===== hdl/recurrence_next_date.sv =====
// Next occurrence of a recurring calendar event.
//
// Input channel req_*: one transfer carries a UTC Unix time in seconds and a
// recurrence kind (once, minute, hour, day, week, monthly same weekday,
// monthly, yearly). Output channel rsp_*: one transfer per input, carrying
// the next occurrence in seconds (33 bits, never wraps).
//
// Items are handled one at a time. Fixed-span kinds (once..week) go from the
// input registers through the day count, span and sum steps; the calendar
// kinds also go through the civil date conversion, a chain of six registered
// steps (some of them constant reciprocal multiplies), before the span step.
// req_tready is high only while the controller is idle, so a new item is
// taken only once the last one has been through its sum step.
// The result sits in an output register; the next input is taken while it
// waits. If the receiver stalls, the block holds its finished result in the
// last step until the output register is free.
// Reset (synchronous) returns the controller to idle and drops rsp_tvalid.
module recurrence_next_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] start_time
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [32:0] next_time, rest zero
);

   rnd_pkg::cmd_type    cmd;
   rnd_pkg::status_type status;

   rnd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rnd_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // an accepted item always starts the day count next
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (cmd.step == rnd_pkg::STEP_DAYS))
      else $error("accepted item did not start the day count");

   // no new item is taken in the cycle the result is written
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && (cmd.step == rnd_pkg::STEP_SUM)))
      else $error("input taken during result write");

   // writing the result raises the output valid
   assert property (@(posedge clock) disable iff (reset)
      (cmd.step == rnd_pkg::STEP_SUM) |=> rsp_tvalid)
      else $error("result written but not presented");

   // output valid rises only after a result write
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.step == rnd_pkg::STEP_SUM))
      else $error("output valid without a result");
`endif

endmodule

// ===== test/recurrence_next_date_tb.sv =====
`timescale 1ns / 100ps

module recurrence_next_date_tb;

   localparam int DIRECTED_ROWS = 25;
   localparam int TOTAL_ITEMS   = 1650;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 16;
   localparam int REPORT_LIMIT  = 10;

   // Spans in seconds
   localparam longint unsigned SPAN_MINUTE = 60;
   localparam longint unsigned SPAN_HOUR   = 3600;
   localparam longint unsigned SPAN_DAY    = 86400;
   localparam longint unsigned SPAN_WEEK   = 604800;
   localparam int              WEEK_STEPS  = 5;

   // One row of the directed table; next_time is only used where known is set
   typedef struct packed {
      logic [31:0] start_time;
      logic [2:0]  kind;
      logic        known;
      logic [32:0] next_time;
   } date_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] start_time
   logic [2:0]  req_tuser = '0;   // [2:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [32:0] next_time, rest zero

   logic [32:0] pending_next_times [$];
   int          items_taken = 0;
   int          error_count = 0;

   date_row_type date_rows [0:DIRECTED_ROWS-1] = '{
      // epoch, every kind; fixed spans and 1970 month/year lengths are obvious
      {32'd0, rnd_pkg::KIND_ONCE,    1'b1, 33'd0},
      {32'd0, rnd_pkg::KIND_MINUTE,  1'b1, 33'd60},
      {32'd0, rnd_pkg::KIND_HOUR,    1'b1, 33'd3600},
      {32'd0, rnd_pkg::KIND_DAY,     1'b1, 33'd86400},
      {32'd0, rnd_pkg::KIND_WEEK,    1'b1, 33'd604800},
      {32'd0, rnd_pkg::KIND_WEEKDAY, 1'b0, 33'd0},
      {32'd0, rnd_pkg::KIND_MONTHLY, 1'b1, 33'd2678400},
      {32'd0, rnd_pkg::KIND_YEARLY,  1'b1, 33'd31536000},
      // top of the time range, sums with a nonzero span carry into bit 32
      {32'hFFFF_FFFF, rnd_pkg::KIND_ONCE,    1'b1, 33'd4294967295},
      {32'hFFFF_FFFF, rnd_pkg::KIND_MINUTE,  1'b1, 33'd4294967355},
      {32'hFFFF_FFFF, rnd_pkg::KIND_HOUR,    1'b1, 33'd4294970895},
      {32'hFFFF_FFFF, rnd_pkg::KIND_DAY,     1'b1, 33'd4295053695},
      {32'hFFFF_FFFF, rnd_pkg::KIND_WEEK,    1'b1, 33'd4295572095},
      {32'hFFFF_FFFF, rnd_pkg::KIND_WEEKDAY, 1'b0, 33'd0},
      {32'hFFFF_FFFF, rnd_pkg::KIND_MONTHLY, 1'b0, 33'd0},
      {32'hFFFF_FFFF, rnd_pkg::KIND_YEARLY,  1'b0, 33'd0},
      // first of a 31-day month and of a leap February: five week steps
      {32'd1704067200, rnd_pkg::KIND_WEEKDAY, 1'b0, 33'd0},
      {32'd1706745600, rnd_pkg::KIND_WEEKDAY, 1'b0, 33'd0},
      {32'd1706745600, rnd_pkg::KIND_MONTHLY, 1'b0, 33'd0},
      // 2000 is a leap year, 2100 is not
      {32'd950572800,  rnd_pkg::KIND_YEARLY,  1'b0, 33'd0},
      {32'd4105123200, rnd_pkg::KIND_MONTHLY, 1'b0, 33'd0},
      {32'd4105123200, rnd_pkg::KIND_YEARLY,  1'b0, 33'd0},
      // last second of a leap February: one week step leaves the month
      {32'd1709251199, rnd_pkg::KIND_WEEKDAY, 1'b0, 33'd0},
      {32'hAAAA_AAAA,  rnd_pkg::KIND_WEEKDAY, 1'b0, 33'd0},
      {32'h5555_5555,  rnd_pkg::KIND_MONTHLY, 1'b0, 33'd0}
   };

   recurrence_next_date dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Gregorian year and month (1..12) of a Unix time
   function automatic void split_date(input longint unsigned secs,
                                      output int unsigned year,
                                      output int unsigned month);
      longint unsigned days, era, doe, yoe, doy, mp, mon;
      days  = secs / SPAN_DAY + 64'd719468;
      era   = days / 64'd146097;
      doe   = days - era * 64'd146097;
      yoe   = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
      doy   = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
      mp    = (64'd5 * doy + 64'd2) / 64'd153;
      mon   = (mp < 64'd10) ? mp + 64'd3 : mp - 64'd9;
      year  = int'(yoe + era * 64'd400 + ((mon <= 64'd2) ? 64'd1 : 64'd0));
      month = int'(mon);
   endfunction

   function automatic logic [32:0] next_occurrence(input logic [31:0] start_time,
                                                   input logic [2:0] kind);
      longint unsigned t, r, month_days;
      int unsigned     year, month, year2, month2;
      bit              leap, moved;
      int              step;
      t = longint'(start_time);
      split_date(t, year, month);
      leap = (year % 4 == 0) && ((year % 400 == 0) || (year % 100 != 0));
      case (kind)
         rnd_pkg::KIND_ONCE:   r = t;
         rnd_pkg::KIND_MINUTE: r = t + SPAN_MINUTE;
         rnd_pkg::KIND_HOUR:   r = t + SPAN_HOUR;
         rnd_pkg::KIND_DAY:    r = t + SPAN_DAY;
         rnd_pkg::KIND_WEEK:   r = t + SPAN_WEEK;
         rnd_pkg::KIND_WEEKDAY: begin
            // whole weeks until the month differs, at most five
            r     = t;
            moved = 1'b0;
            for (step = 0; step < WEEK_STEPS && !moved; step++) begin
               r = r + SPAN_WEEK;
               split_date(r, year2, month2);
               moved = (month2 != month);
            end
         end
         rnd_pkg::KIND_MONTHLY: begin
            if (month == int'(rnd_pkg::MONTH_FEB)) begin
               month_days = leap ? 29 : 28;
            end else if (month == int'(rnd_pkg::MONTH_APR) ||
                         month == int'(rnd_pkg::MONTH_JUN) ||
                         month == int'(rnd_pkg::MONTH_SEP) ||
                         month == int'(rnd_pkg::MONTH_NOV)) begin
               month_days = 30;
            end else begin
               month_days = 31;
            end
            r = t + SPAN_DAY * month_days;
         end
         default: r = t + SPAN_DAY * (leap ? 366 : 365);
      endcase
      return r[32:0];
   endfunction

   // Random start times, weighted towards midnights and the range ends
   function automatic logic [31:0] random_start();
      logic [31:0] t;
      case ($urandom_range(7, 0))
         0: t = 32'hFFFF_FFFF - 32'($urandom_range(40000000, 0));
         1: t = 32'($urandom_range(3000000, 0));
         2, 3: begin
            t = $urandom;
            t = t - (t % 32'd86400);
            if ($urandom_range(1, 0)) begin
               t = t - 32'd1;
            end else begin
               t = t + 32'($urandom_range(59, 0));
            end
         end
         default: t = $urandom;
      endcase
      return t;
   endfunction

   // Offer one item and hold it until the block takes it
   task automatic offer_date(input logic [31:0] start_time, input logic [2:0] kind,
                             input logic known, input logic [32:0] next_time);
      req_tvalid <= 1'b1;
      req_tdata  <= start_time;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_next_times.push_back(known ? next_time
                                         : next_occurrence(start_time, kind));
      items_taken++;
   endtask

   // Stimulus: directed table, then random items, sent in bursts
   initial begin
      int          item;
      int          burst_left;
      int          gap;
      logic [31:0] start_time;
      logic [2:0]  kind;
      burst_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (item = 0; item < TOTAL_ITEMS; item++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(20, 1);
         end
         burst_left--;
         if (item < DIRECTED_ROWS) begin
            offer_date(date_rows[item].start_time, date_rows[item].kind,
                       date_rows[item].known, date_rows[item].next_time);
         end else begin
            start_time = random_start();
            kind       = 3'($urandom_range(7, 0));
            offer_date(start_time, kind, 1'b0, 33'd0);
         end
      end
      req_tvalid <= 1'b0;

      // drain, then allow the block's latency to pass
      while (pending_next_times.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Receiver: phases of full rate, a rotating stall mask and random stalls,
   // plus one long hold-off so that the block backs up into its input
   initial begin
      int       phase_len;
      int       mode;
      bit       held;
      logic [7:0] mask;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (!held && items_taken >= 300) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            phase_len = $urandom_range(100, 20);
            mode      = $urandom_range(2, 0);
            mask      = 8'($urandom_range(255, 1));
            repeat (phase_len) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: begin
                     rsp_tready <= mask[0];
                     mask = {mask[0], mask[7:1]};
                  end
                  default: rsp_tready <= ($urandom_range(3, 0) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      logic [32:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_next_times.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("%0t: result with nothing pending, rsp_tdata=%h",
                        $realtime, rsp_tdata);
            end
         end else begin
            want = pending_next_times.pop_front();
            if (rsp_tdata[32:0] !== want || rsp_tdata[39:33] !== 7'd0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: next_time expected %0d got %0d (pad %b)",
                           $realtime, want, rsp_tdata[32:0], rsp_tdata[39:33]);
               end
            end
         end
      end
   end

   // Overall time limit
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
